// ===== src/audio_highpass_lowpass_gain_assert.svh =====
// ----------------------------------------------------------------------------
// audio_highpass_lowpass_gain assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_HIGHPASS_LOWPASS_GAIN_ASSERT_SVH
`define AUDIO_HIGHPASS_LOWPASS_GAIN_ASSERT_SVH

// same-cycle implication
`define AHLG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AHLG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/ahlg_pkg.sv =====
// ----------------------------------------------------------------------------
// ahlg_pkg
// Shared constants and types of the high-pass, low-pass and gain block.
// ----------------------------------------------------------------------------
package ahlg_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned CoefW         = 17;
  localparam int unsigned PcmW          = 16;
  localparam int unsigned GainW         = 10;
  localparam int unsigned CoefFracBits  = 14;
  localparam int unsigned GainFracBits  = 8;
  localparam int unsigned LpfShift      = 8;

  localparam logic signed [CoefW-1:0] HpfB0  = 17'sd15788;
  localparam logic signed [CoefW-1:0] HpfB1  = -17'sd31577;
  localparam logic signed [CoefW-1:0] HpfB2  = 17'sd15788;
  localparam logic signed [CoefW-1:0] HpfA1  = -17'sd31555;
  localparam logic signed [CoefW-1:0] HpfA2  = 17'sd15215;
  localparam logic signed [CoefW-1:0] LpfNew = 17'sd217;
  localparam logic signed [CoefW-1:0] LpfOld = 17'sd39;

  localparam logic signed [DataW-1:0] SatHi = 32'sd32767;
  localparam logic signed [DataW-1:0] SatLo = -32'sd32768;

  localparam logic [GainW-1:0] GainReset = 10'd128;

  typedef struct packed {
    logic mul_en;
    logic sub;
  } mac_ctrl_t;

endpackage

// ===== src/ahlg_mac.sv =====
// ----------------------------------------------------------------------------
// ahlg_mac
// Shared multiplier with a registered product and one add/subtract stage.
// ----------------------------------------------------------------------------
module ahlg_mac (
  input  logic                                 clk_i,
  input  ahlg_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [ahlg_pkg::DataW-1:0]    mul_a_i,
  input  logic signed [ahlg_pkg::CoefW-1:0]    mul_b_i,
  input  logic signed [ahlg_pkg::DataW-1:0]    add_a_i,
  output logic signed [ahlg_pkg::DataW-1:0]    prod_o,
  output logic signed [ahlg_pkg::DataW-1:0]    sum_o
);

  logic signed [ahlg_pkg::DataW+ahlg_pkg::CoefW-1:0] full_prod;
  logic signed [ahlg_pkg::DataW-1:0]                 prod_q;

  assign full_prod = mul_a_i * mul_b_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= full_prod[ahlg_pkg::DataW-1:0];
    end
  end

  assign sum_o  = ctrl_i.sub ? (add_a_i - prod_q) : (add_a_i + prod_q);
  assign prod_o = prod_q;

endmodule

// ===== src/audio_highpass_lowpass_gain.sv =====
// ----------------------------------------------------------------------------
// audio_highpass_lowpass_gain
// Mono PCM conditioning: high-pass biquad, one-pole low-pass, Q8 gain and
// saturation, copied to left and right.
// ----------------------------------------------------------------------------
// Input channel pcm_valid_i / pcm_ready_o carries one signed 16-bit sample
// per word. Output channel out_valid_o / out_ready_i carries left_out_o and
// right_out_o, which always hold the same value.
// A sample runs through a ten-step sequence on one shared multiplier with a
// registered product: eight products and one low-pass add step, then the
// saturation step. pcm_ready_o is high only while the sequencer is idle, so
// the next sample is accepted only after the sequence has returned to idle.
// The output register lets a new sample be accepted while a result waits;
// if the receiver still stalls when the next result is ready, the final
// step holds until the output register is free.
// cfg_we_i with cfg_wdata_i writes the gain (256 is unity).
// Reset clears the filter delays and the low-pass history, sets the gain to
// 128 and empties the output register.
// ----------------------------------------------------------------------------
module audio_highpass_lowpass_gain (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ahlg_pkg::GainW-1:0]         cfg_wdata_i,
  input  logic                               pcm_valid_i,
  output logic                               pcm_ready_o,
  input  logic signed [ahlg_pkg::PcmW-1:0]   pcm_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ahlg_pkg::PcmW-1:0]   left_out_o,
  output logic signed [ahlg_pkg::PcmW-1:0]   right_out_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StS0   = 4'd1;
  localparam logic [3:0] StS1   = 4'd2;
  localparam logic [3:0] StS2   = 4'd3;
  localparam logic [3:0] StS3   = 4'd4;
  localparam logic [3:0] StS4   = 4'd5;
  localparam logic [3:0] StS5   = 4'd6;
  localparam logic [3:0] StS6   = 4'd7;
  localparam logic [3:0] StS7   = 4'd8;
  localparam logic [3:0] StS8   = 4'd9;
  localparam logic [3:0] StS9   = 4'd10;

  logic [3:0]                              state_q, state_d;
  logic [ahlg_pkg::GainW-1:0]              gain_q;
  logic signed [ahlg_pkg::DataW-1:0]       x_q, acc_q, hp_q, d1_q, d2_q, lp_q;
  logic signed [ahlg_pkg::PcmW-1:0]        out_q;
  logic                                    out_valid_q;

  ahlg_pkg::mac_ctrl_t                     mac_ctrl;
  logic signed [ahlg_pkg::DataW-1:0]       mul_a, add_a, prod, sum;
  logic signed [ahlg_pkg::CoefW-1:0]       mul_b;
  logic signed [ahlg_pkg::DataW-1:0]       hp_now, lp_now, g_val;
  logic signed [ahlg_pkg::PcmW-1:0]        sat_val;
  logic                                    in_acc, out_free;

  assign pcm_ready_o = (state_q == StIdle);
  assign in_acc      = pcm_valid_i && pcm_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign hp_now = acc_q >>> ahlg_pkg::CoefFracBits;
  assign lp_now = sum >>> ahlg_pkg::LpfShift;
  assign g_val  = prod >>> ahlg_pkg::GainFracBits;

  always_comb begin
    if (g_val > ahlg_pkg::SatHi) begin
      sat_val = ahlg_pkg::SatHi[ahlg_pkg::PcmW-1:0];
    end else if (g_val < ahlg_pkg::SatLo) begin
      sat_val = ahlg_pkg::SatLo[ahlg_pkg::PcmW-1:0];
    end else begin
      sat_val = g_val[ahlg_pkg::PcmW-1:0];
    end
  end

  always_comb begin
    mac_ctrl = '0;
    mul_a    = x_q;
    mul_b    = ahlg_pkg::HpfB0;
    add_a    = '0;
    state_d  = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) state_d = StS0;
      end
      StS0: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = StS1;
      end
      StS1: begin
        mac_ctrl.mul_en = 1'b1;
        mul_b           = ahlg_pkg::HpfB1;
        add_a           = d1_q;
        state_d         = StS2;
      end
      StS2: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = hp_now;
        mul_b           = ahlg_pkg::HpfA1;
        add_a           = d2_q;
        state_d         = StS3;
      end
      StS3: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.sub    = 1'b1;
        mul_b           = ahlg_pkg::HpfB2;
        add_a           = acc_q;
        state_d         = StS4;
      end
      StS4: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = hp_q;
        mul_b           = ahlg_pkg::HpfA2;
        state_d         = StS5;
      end
      StS5: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.sub    = 1'b1;
        mul_a           = hp_q;
        mul_b           = ahlg_pkg::LpfNew;
        add_a           = acc_q;
        state_d         = StS6;
      end
      StS6: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = lp_q;
        mul_b           = ahlg_pkg::LpfOld;
        state_d         = StS7;
      end
      StS7: begin
        add_a   = acc_q;
        state_d = StS8;
      end
      StS8: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = lp_q;
        mul_b           = signed'({{(ahlg_pkg::CoefW-ahlg_pkg::GainW){1'b0}}, gain_q});
        state_d         = StS9;
      end
      StS9: begin
        if (out_free) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  ahlg_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .add_a_i (add_a),
    .prod_o  (prod),
    .sum_o   (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gain_q      <= ahlg_pkg::GainReset;
      d1_q        <= '0;
      d2_q        <= '0;
      lp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) gain_q <= cfg_wdata_i;
      if (state_q == StS3) d1_q <= sum;
      if (state_q == StS5) d2_q <= sum;
      if (state_q == StS7) lp_q <= lp_now;
      if (state_q == StS9 && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) x_q <= {{(ahlg_pkg::DataW-ahlg_pkg::PcmW){pcm_in_i[ahlg_pkg::PcmW-1]}}, pcm_in_i};
    if (state_q == StS1 || state_q == StS2 || state_q == StS4 || state_q == StS6) begin
      acc_q <= sum;
    end
    if (state_q == StS2) hp_q <= hp_now;
    if (state_q == StS9 && out_free) out_q <= sat_val;
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_q;
  assign right_out_o = out_q;

endmodule

// ===== src/ahlg_checker.sv =====
// ----------------------------------------------------------------------------
// ahlg_checker
// Port-level checks of the high-pass, low-pass and gain block.
// ----------------------------------------------------------------------------
`include "audio_highpass_lowpass_gain_assert.svh"

module ahlg_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pcm_valid_i,
  input  logic                             pcm_ready_o,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  logic signed [ahlg_pkg::PcmW-1:0] left_out_o,
  input  logic signed [ahlg_pkg::PcmW-1:0] right_out_o
);

  `AHLG_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(left_out_o))
  `AHLG_ASSERT_IMP(a_lr_same, out_valid_o, left_out_o == right_out_o)
  `AHLG_ASSERT_NXT(a_busy_after_acc, pcm_valid_i && pcm_ready_o, !pcm_ready_o)
  `AHLG_ASSERT_NXT(a_no_early_out, pcm_valid_i && pcm_ready_o, !$rose(out_valid_o))

endmodule

bind audio_highpass_lowpass_gain ahlg_checker u_ahlg_checker (.*);
